// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the decoder RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rcpd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcpd_pkg
// Types, codes and constants of the rolling-code pulse decoder.
// ---------------------------------------------------------------------------
package rcpd_pkg;

	// Item modes
	localparam logic [1:0] MODE_EDGE  = 2'd0;
	localparam logic [1:0] MODE_REARM = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	// Reported status codes
	localparam logic [1:0] STATUS_OFF    = 2'd0;
	localparam logic [1:0] STATUS_LISTEN = 2'd1;
	localparam logic [1:0] STATUS_SYNC   = 2'd2;
	localparam logic [1:0] STATUS_READY  = 2'd3;

	// Register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_NOMINAL   = 2'd0;
	localparam logic [1:0] REG_TOLERANCE = 2'd1;
	localparam logic [1:0] REG_NOISE     = 2'd2;
	localparam logic [1:0] REG_PREAMBLE  = 2'd3;

	localparam int ADDR_W = 4;

	// Register reset values
	localparam logic [15:0] NOMINAL_RST   = 16'd400;
	localparam logic [15:0] TOLERANCE_RST = 16'd100;
	localparam logic [15:0] NOISE_RST     = 16'd100;
	localparam logic [7:0]  PREAMBLE_RST  = 8'd10;

	// Frame layout
	localparam int WORD_BITS = 32;
	localparam int FRAME_BITS = 66;
	localparam int BCNT_W = 7;
	localparam logic [BCNT_W-1:0] HOP_END   = BCNT_W'(WORD_BITS);
	localparam logic [BCNT_W-1:0] FIXED_END = BCNT_W'(2 * WORD_BITS);
	localparam logic [BCNT_W-1:0] FRAME_END = BCNT_W'(FRAME_BITS);
	localparam logic [BCNT_W-1:0] LAST_BIT  = BCNT_W'(FRAME_BITS - 1);

	localparam logic [7:0] PREAMBLE_MAX = 8'd255;

	// Receiver phase, one-hot
	typedef enum logic [3:0] {
		PH_OFF    = 4'b0001,
		PH_LISTEN = 4'b0010,
		PH_SYNC   = 4'b0100,
		PH_READY  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        level_after_edge;
		logic [15:0] interval_us;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hopping_code;
		logic [31:0] fixed_code;
		logic [1:0]  frame_flags;
	} result_t;

	typedef struct packed {
		logic [15:0] nominal_pulse_us;
		logic [15:0] tolerance_us;
		logic [15:0] noise_floor_us;
		logic [7:0]  min_preamble;
	} cfg_t;

	// Core state seen by the top-level checks
	typedef struct packed {
		logic              ready_phase;
		logic [BCNT_W-1:0] bit_count;
	} core_mon_t;

	// Output buffer occupancy
	typedef struct packed {
		logic head_valid;
		logic skid_valid;
	} ob_mon_t;

endpackage

// ===== hdl/rcpd_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcpd_regs
// APB-style configuration registers with read-back.
// ---------------------------------------------------------------------------
module rcpd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output rcpd_pkg::cfg_t              cfg
);

	rcpd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nominal_pulse_us <= rcpd_pkg::NOMINAL_RST;
			cfg_q.tolerance_us     <= rcpd_pkg::TOLERANCE_RST;
			cfg_q.noise_floor_us   <= rcpd_pkg::NOISE_RST;
			cfg_q.min_preamble     <= rcpd_pkg::PREAMBLE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				rcpd_pkg::REG_NOMINAL:   cfg_q.nominal_pulse_us <= pwdata[15:0];
				rcpd_pkg::REG_TOLERANCE: cfg_q.tolerance_us     <= pwdata[15:0];
				rcpd_pkg::REG_NOISE:     cfg_q.noise_floor_us   <= pwdata[15:0];
				rcpd_pkg::REG_PREAMBLE:  cfg_q.min_preamble     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			rcpd_pkg::REG_NOMINAL:   prdata = {16'd0, cfg_q.nominal_pulse_us};
			rcpd_pkg::REG_TOLERANCE: prdata = {16'd0, cfg_q.tolerance_us};
			rcpd_pkg::REG_NOISE:     prdata = {16'd0, cfg_q.noise_floor_us};
			rcpd_pkg::REG_PREAMBLE:  prdata = {24'd0, cfg_q.min_preamble};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/rcpd_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcpd_core
// Receiver state and the combinational next-state logic for one item (edge, rearm or stop).
// ---------------------------------------------------------------------------
module rcpd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  rcpd_pkg::cfg_t      cfg,
	input  logic                take,
	input  rcpd_pkg::item_t     item,
	output rcpd_pkg::result_t   result_d,
	output rcpd_pkg::core_mon_t mon
);

	localparam int BW = rcpd_pkg::BCNT_W;

	rcpd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       pre_cnt_q, pre_cnt_d;
	logic [BW-1:0]    bit_cnt_q, bit_cnt_d;
	logic [31:0]      hop_q, hop_d;
	logic [31:0]      fixed_q, fixed_d;
	logic [1:0]       flags_q, flags_d;
	logic [15:0]      bit_time_q, bit_time_d;
	logic [15:0]      last_high_q, last_high_d;

	logic [15:0]        hi, lo, min_w, diff;
	logic signed [17:0] lower_s, min_s;
	logic [16:0]        upper, end_thr;
	logic               in_win, square, gap;
	logic               push_en, push_val;
	logic [18:0]        hi_x8;
	logic [19:0]        hi_x12;
	logic [17:0]        hi_x3, lo_x3, bt_x3;

	assign hi = last_high_q;
	assign lo = item.interval_us;

	// Pulse width and ratio tests
	always_comb begin
		min_w   = (hi < lo) ? hi : lo;
		lower_s = $signed({2'b00, cfg.nominal_pulse_us}) - $signed({2'b00, cfg.tolerance_us});
		min_s   = $signed({2'b00, min_w});
		upper   = {1'b0, cfg.nominal_pulse_us} + {1'b0, cfg.tolerance_us};
		in_win  = (min_s >= lower_s) && ({1'b0, min_w} <= upper);
		diff    = (hi >= lo) ? (hi - lo) : (lo - hi);
		square  = diff < cfg.tolerance_us;
		hi_x8   = {hi, 3'b000};
		hi_x12  = {1'b0, hi_x8} + {2'b00, hi, 2'b00};
		gap     = ({3'b000, lo} > hi_x8) && ({4'b0000, lo} < hi_x12)
			&& (pre_cnt_q > cfg.min_preamble);
		hi_x3   = {2'b00, hi} + {1'b0, hi, 1'b0};
		lo_x3   = {2'b00, lo} + {1'b0, lo, 1'b0};
		bt_x3   = {2'b00, bit_time_q} + {1'b0, bit_time_q, 1'b0};
		end_thr = bt_x3[17:1];
	end

	// Next state for the item at the input
	always_comb begin
		phase_d     = phase_q;
		pre_cnt_d   = pre_cnt_q;
		bit_cnt_d   = bit_cnt_q;
		hop_d       = hop_q;
		fixed_d     = fixed_q;
		flags_d     = flags_q;
		bit_time_d  = bit_time_q;
		last_high_d = last_high_q;
		push_en     = 1'b0;
		push_val    = 1'b0;

		unique case (item.mode)
			rcpd_pkg::MODE_REARM: phase_d = rcpd_pkg::PH_LISTEN;
			rcpd_pkg::MODE_STOP:  phase_d = rcpd_pkg::PH_OFF;
			rcpd_pkg::MODE_EDGE: begin
				if (item.interval_us > cfg.noise_floor_us) begin
					if (item.level_after_edge) begin
						// Low time closes a pulse
						if (in_win && phase_q == rcpd_pkg::PH_LISTEN) begin
							if (square) begin
								if (pre_cnt_q != rcpd_pkg::PREAMBLE_MAX) begin
									pre_cnt_d = pre_cnt_q + 8'd1;
								end
							end else if (gap) begin
								bit_cnt_d  = '0;
								bit_time_d = '0;
								hop_d      = '0;
								fixed_d    = '0;
								flags_d    = '0;
								phase_d    = rcpd_pkg::PH_SYNC;
								pre_cnt_d  = '0;
							end else begin
								pre_cnt_d = '0;
							end
						end else if (in_win && phase_q == rcpd_pkg::PH_SYNC) begin
							if (hi < lo) begin
								if (hi_x3 > {2'b00, lo}) begin
									push_en  = 1'b1;
									push_val = 1'b1;
									if (bit_time_q == 16'd0) begin
										bit_time_d = hi;
									end
								end else begin
									phase_d   = rcpd_pkg::PH_LISTEN;
									pre_cnt_d = '0;
								end
							end else if (lo_x3 > {2'b00, hi}) begin
								push_en  = 1'b1;
								push_val = 1'b0;
							end else begin
								phase_d   = rcpd_pkg::PH_LISTEN;
								pre_cnt_d = '0;
							end
						end
					end else begin
						// High time: store it, judge the end bit
						last_high_d = item.interval_us;
						if (phase_q == rcpd_pkg::PH_SYNC && bit_cnt_q == rcpd_pkg::LAST_BIT) begin
							push_en  = 1'b1;
							push_val = {1'b0, item.interval_us} < end_thr;
						end
					end
				end
			end
			default: ;
		endcase

		// Shift the decoded bit into its word
		if (push_en && bit_cnt_q < rcpd_pkg::FRAME_END) begin
			if (bit_cnt_q < rcpd_pkg::HOP_END) begin
				hop_d = {hop_q[30:0], push_val};
			end else if (bit_cnt_q < rcpd_pkg::FIXED_END) begin
				fixed_d = {fixed_q[30:0], push_val};
			end else begin
				flags_d = {flags_q[0], push_val};
			end
			bit_cnt_d = bit_cnt_q + BW'(1);
			if (bit_cnt_d == rcpd_pkg::FRAME_END) begin
				phase_d = rcpd_pkg::PH_READY;
			end
		end
	end

	// Advance state on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rcpd_pkg::PH_LISTEN;
			pre_cnt_q   <= '0;
			bit_cnt_q   <= '0;
			hop_q       <= '0;
			fixed_q     <= '0;
			flags_q     <= '0;
			bit_time_q  <= '0;
			last_high_q <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			pre_cnt_q   <= pre_cnt_d;
			bit_cnt_q   <= bit_cnt_d;
			hop_q       <= hop_d;
			fixed_q     <= fixed_d;
			flags_q     <= flags_d;
			bit_time_q  <= bit_time_d;
			last_high_q <= last_high_d;
		end
	end

	// Encode the phase as a status code
	always_comb begin
		unique case (phase_d)
			rcpd_pkg::PH_OFF:    result_d.status = rcpd_pkg::STATUS_OFF;
			rcpd_pkg::PH_LISTEN: result_d.status = rcpd_pkg::STATUS_LISTEN;
			rcpd_pkg::PH_SYNC:   result_d.status = rcpd_pkg::STATUS_SYNC;
			rcpd_pkg::PH_READY:  result_d.status = rcpd_pkg::STATUS_READY;
			default:             result_d.status = rcpd_pkg::STATUS_OFF;
		endcase
		result_d.hopping_code = hop_d;
		result_d.fixed_code   = fixed_d;
		result_d.frame_flags  = flags_d;
	end

	assign mon.ready_phase = (phase_q == rcpd_pkg::PH_READY);
	assign mon.bit_count   = bit_cnt_q;

endmodule

// ===== hdl/rcpd_outbuf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcpd_outbuf
// Two-entry result buffer: an output register and a skid entry behind it.
// ---------------------------------------------------------------------------
module rcpd_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcpd_pkg::result_t din,
	output logic              space,
	output logic              result_valid,
	input  logic              result_ready,
	output rcpd_pkg::result_t result,
	output rcpd_pkg::ob_mon_t mon
);

	logic              head_valid_q, skid_valid_q;
	rcpd_pkg::result_t head_q, skid_q;
	logic              pop;

	assign pop          = head_valid_q & result_ready;
	assign space        = ~skid_valid_q;
	assign result_valid = head_valid_q;
	assign result       = head_q;

	// Control: head refills from skid first, then from the new item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (!head_valid_q) begin
			head_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the control above
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (!head_valid_q) begin
			if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign mon.head_valid = head_valid_q;
	assign mon.skid_valid = skid_valid_q;

endmodule

// ===== hdl/rolling_code_pulse_decoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rolling_code_pulse_decoder_top
// Pulse-width decoder for a 66-bit rolling-code frame, one edge per item.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  item      item_valid / item_ready   rcpd_pkg::item_t
//  result    result_valid/result_ready rcpd_pkg::result_t
//  config    APB psel/penable/pwrite   paddr[3:2] index, pwdata[15:0]
//
//  One item per clock while item_ready is high; its result is in the output register
//  the next cycle, or in the skid entry while the output register holds an earlier result.
//  The receiver state updates in the cycle the item is accepted.
//  A two-entry buffer (output register plus skid) holds results; item_ready
//  drops only while both entries are full.
//  Reset: receiver listening, words and counts zero, registers at defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rolling_code_pulse_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  rcpd_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output rcpd_pkg::result_t           result
);

	rcpd_pkg::cfg_t      cfg;
	rcpd_pkg::result_t   next_result;
	rcpd_pkg::core_mon_t core_mon;
	rcpd_pkg::ob_mon_t   ob_mon;
	logic                take;
	logic                space;

	assign item_ready = space;
	assign take       = item_valid & space;

	rcpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcpd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.take     (take),
		.item     (item),
		.result_d (next_result),
		.mon      (core_mon)
	);

	rcpd_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (take),
		.din          (next_result),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mon          (ob_mon)
	);

	// Checks
	`ASSERT_IMP(a_skid_behind_head, ob_mon.skid_valid, ob_mon.head_valid, "skid full, head empty")
	`ASSERT_NEXT(a_take_gives_result, take, result_valid, "accepted item left no result")
	`ASSERT_IMP(a_ready_has_frame, core_mon.ready_phase, core_mon.bit_count == rcpd_pkg::FRAME_END, "frame ready without 66 bits")
	`ASSERT_IMP(a_bit_count_bound, 1'b1, core_mon.bit_count <= rcpd_pkg::FRAME_END, "bit count past frame length")

endmodule
